// File: src/mqed_pkg.sv
// ----------------------------------------------------------------------------
// mqed_pkg: shared types and constants for the expedite deque bank
// Sizes of the queue bank, item structs and outcome codes.
// ----------------------------------------------------------------------------
package mqed_pkg;

    // Bank geometry
    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_BITS     = 16;

    // Fixed field widths of the item interface
    localparam int KIND_W  = 1;
    localparam int QIDX_W  = 5;
    localparam int TID_W   = 16;
    localparam int FILL_W  = 4;

    // Derived storage widths
    localparam int SLOT_COUNT = NUM_QUEUES * QUEUE_DEPTH;
    localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSEL_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TAKE = 1'b1;

    typedef enum logic [1:0] {
        OUT_ADDED = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_TAKEN = 2'd2,
        OUT_EMPTY = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [QIDX_W-1:0] queue_index;
        logic [TID_W-1:0]  entry_id;
        logic              urgent;
    } t_in_item;

    typedef struct packed {
        t_outcome          outcome;
        logic [TID_W-1:0]  taken_id;
        logic              taken_urgent;
        logic [FILL_W-1:0] fill_after;
    } t_out_item;

    // One ring slot of the entry store
    typedef struct packed {
        logic               urgent;
        logic [ID_BITS-1:0] id;
    } t_slot;

endpackage

// File: src/multi_queue_expedite_deque_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_expedite_deque_unit: bank of bounded deques with urgent insert
// Pipeline: the item is held in the stage 1 input register, and its result
// in the stage 2 result register; a stalled result holds stage 1.
// Throughput: one item per cycle unless the result output stalls; each
// item touches one count, one head pointer and one entry memory slot in a single pass.
// Reset: synchronous, active low; clears all head pointers, fill counts and
// valid flags at once. The entry memory is not cleared.
// ----------------------------------------------------------------------------
module multi_queue_expedite_deque_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mqed_pkg::t_in_item  i_in_data,
    // result output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mqed_pkg::t_out_item o_out_data
);
    import mqed_pkg::*;

    // ------------------------------------------------------------------
    // Per-queue ring state in flops: head pointer and fill count
    // ------------------------------------------------------------------
    logic [PTR_W-1:0] r_head [NUM_QUEUES];
    logic [CNT_W-1:0] r_cnt  [NUM_QUEUES];

    // Entry memory: one ID plus urgent flag per slot, read data registered
    t_slot r_mem [SLOT_COUNT];
    t_slot r_rd_slot;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic     r_s1_vld;
    t_in_item r_s1;

    // Stage 2: result register (taken slot comes from r_rd_slot)
    logic              r_out_vld;
    t_outcome          r_out_outcome;
    logic              r_out_take;
    logic [FILL_W-1:0] r_out_fill;

    // Handshake: stage 1 moves on when the result register is free or drains.
    logic s2_free;
    logic commit;
    logic in_xfer;

    assign s2_free    = !r_out_vld || !i_out_stall;
    assign commit     = r_s1_vld && s2_free;
    assign o_in_stall = r_s1_vld && !s2_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Single-pass operation logic on the item in stage 1.
    // All earlier items have already committed, so the flop state is current.
    // ------------------------------------------------------------------
    logic              q_ok;
    logic [QSEL_W-1:0] qsel;
    logic [PTR_W-1:0]  head;
    logic [CNT_W-1:0]  cnt;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_dec;
    logic [PTR_W-1:0]  head_inc;
    logic [ADDR_W-1:0] base;

    logic              n_head_we;
    logic [PTR_W-1:0]  n_head;
    logic              n_cnt_we;
    logic [CNT_W-1:0]  n_cnt;
    logic              mem_we;
    logic [PTR_W-1:0]  wr_ptr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_outcome          n_outcome;
    logic              n_take;
    logic [FILL_W-1:0] n_fill;

    always_comb begin
        q_ok = (32'(r_s1.queue_index) < 32'(NUM_QUEUES));
        qsel = QSEL_W'(r_s1.queue_index);
        head = r_head[qsel];
        cnt  = r_cnt[qsel];
        base = ADDR_W'(32'(qsel) * 32'(QUEUE_DEPTH));

        // ring arithmetic; the head stays below the depth and the count at most the depth, so one compare fixes wrap
        tail_sum = (PTR_W + 1)'(head) + (PTR_W + 1)'(cnt);
        if (32'(tail_sum) >= 32'(QUEUE_DEPTH)) begin
            tail = PTR_W'(32'(tail_sum) - 32'(QUEUE_DEPTH));
        end else begin
            tail = PTR_W'(tail_sum);
        end
        head_dec = (head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head - 1'b1;
        head_inc = (32'(head) == 32'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

        n_head_we = 1'b0;
        n_head    = head;
        n_cnt_we  = 1'b0;
        n_cnt     = cnt;
        mem_we    = 1'b0;
        wr_ptr    = tail;
        n_take    = 1'b0;
        n_outcome = OUT_FULL;

        priority if (!q_ok) begin
            n_outcome = (r_s1.kind == KIND_TAKE) ? OUT_EMPTY : OUT_FULL;
            n_cnt     = '0;
        end else if (r_s1.kind == KIND_ADD) begin
            if (32'(cnt) >= 32'(QUEUE_DEPTH)) begin
                n_outcome = OUT_FULL;
            end else begin
                n_outcome = OUT_ADDED;
                mem_we    = 1'b1;
                n_cnt_we  = 1'b1;
                n_cnt     = cnt + 1'b1;
                if (r_s1.urgent) begin
                    // urgent entry goes in front of the current head
                    wr_ptr    = head_dec;
                    n_head_we = 1'b1;
                    n_head    = head_dec;
                end
            end
        end else begin
            if (cnt == '0) begin
                n_outcome = OUT_EMPTY;
            end else begin
                n_outcome = OUT_TAKEN;
                n_take    = 1'b1;
                n_head_we = 1'b1;
                n_head    = head_inc;
                n_cnt_we  = 1'b1;
                n_cnt     = cnt - 1'b1;
            end
        end

        wr_addr = base + ADDR_W'(wr_ptr);
        rd_addr = base + ADDR_W'(head);
        n_fill  = FILL_W'(n_cnt);
    end

    // ------------------------------------------------------------------
    // Control and ring state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (commit) begin
                r_s1_vld <= 1'b0;
            end

            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (commit && n_head_we) begin
                r_head[qsel] <= n_head;
            end
            if (commit && n_cnt_we) begin
                r_cnt[qsel] <= n_cnt;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_in_data;
        end
        if (commit) begin
            r_out_outcome <= n_outcome;
            r_out_take    <= n_take;
            r_out_fill    <= n_fill;
        end
    end

    // Entry memory: at most one write and one registered read per cycle.
    // A take never writes, so the read always sees every earlier write.
    always_ff @(posedge i_clk) begin
        if (commit && mem_we) begin
            r_mem[wr_addr] <= '{urgent: r_s1.urgent, id: ID_BITS'(r_s1.entry_id)};
        end
        if (commit) begin
            r_rd_slot <= r_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result assembly: taken fields are zero unless a pop happened
    // ------------------------------------------------------------------
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_out_data.outcome      = r_out_outcome;
        o_out_data.taken_id     = r_out_take ? TID_W'(r_rd_slot.id) : '0;
        o_out_data.taken_urgent = r_out_take & r_rd_slot.urgent;
        o_out_data.fill_after   = r_out_fill;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted item always lands in stage 1
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_vld)
        else $error("accepted item missing from stage 1");

    // a committed item always produces a result on the next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_vld)
        else $error("committed item produced no result");

    // the popped flag only rides with a taken outcome
    a_take_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_take) |-> (r_out_outcome == OUT_TAKEN))
        else $error("pop flag without taken outcome");

    // a successful add leaves at least one entry, an empty report leaves none
    a_fill_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_outcome != OUT_ADDED || r_out_fill != '0) &&
                       (r_out_outcome != OUT_EMPTY || r_out_fill == '0)))
        else $error("fill count inconsistent with outcome");

    // the addressed queue never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (32'(cnt) <= 32'(QUEUE_DEPTH)))
        else $error("fill count beyond queue depth");

endmodule
